@@ rtl/core/sthc_pkg.sv @@
// shared types and constants for the shutter tap/hold controller
// no dependencies; imported by every module of the block
`default_nettype none

package sthc_pkg;

    localparam int SHORT_RUN_W = 16;
    localparam int TAP_LIMIT_W = 10;
    localparam int HOLD_W      = 10;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_RUN = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_LIMIT = 1'd1;

    localparam logic [SHORT_RUN_W-1:0] SHORT_RUN_RESET = 16'd15000;
    localparam logic [TAP_LIMIT_W-1:0] TAP_LIMIT_RESET = 10'd200;
    localparam logic [HOLD_W-1:0]      HOLD_MAX        = 10'd1023;

    typedef struct packed {
        logic button_up_pressed;
        logic button_down_pressed;
    } sthc_in_t;

    typedef struct packed {
        logic relay_up_on;
        logic relay_down_on;
        logic timed_run_active;
    } sthc_out_t;

    typedef struct packed {
        logic [SHORT_RUN_W-1:0] short_run_ms;
        logic [TAP_LIMIT_W-1:0] tap_limit_ms;
    } sthc_cfg_t;

    typedef struct packed {
        logic                   up_prev;
        logic                   down_prev;
        logic [HOLD_W-1:0]      up_hold_count;
        logic [HOLD_W-1:0]      down_hold_count;
        logic [SHORT_RUN_W-1:0] run_remaining;
        logic                   run_armed;
        logic                   motor_busy;
        logic                   up_relay;
        logic                   down_relay;
    } sthc_state_t;

endpackage

`default_nettype wire

@@ rtl/core/sthc_cfg_regs.sv @@
// configuration registers: short run length and tap limit
// depends on sthc_pkg
`default_nettype none

module sthc_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [sthc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sthc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output sthc_pkg::sthc_cfg_t                 cfg
);
    import sthc_pkg::*;

    sthc_cfg_t cfg_reg;
    sthc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SHORT_RUN: cfg_next.short_run_ms = cfg_data[SHORT_RUN_W-1:0];
                CFG_TAP_LIMIT: cfg_next.tap_limit_ms = cfg_data[TAP_LIMIT_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_run_ms <= SHORT_RUN_RESET;
            cfg_reg.tap_limit_ms <= TAP_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/core/sthc_step.sv @@
// next-state logic for one millisecond tick: timer, up button, then down button
// depends on sthc_pkg
`default_nettype none

module sthc_step (
    input  wire sthc_pkg::sthc_state_t state,
    input  wire sthc_pkg::sthc_in_t    buttons,
    input  wire sthc_pkg::sthc_cfg_t   cfg,
    output sthc_pkg::sthc_state_t      state_next,
    output sthc_pkg::sthc_out_t        result
);
    import sthc_pkg::*;

    function automatic sthc_state_t handle_button(
        input sthc_state_t            s,
        input logic                   level,
        input logic                   upward,
        input logic                   elapsed,
        input logic [TAP_LIMIT_W-1:0] tap_limit,
        input logic [SHORT_RUN_W-1:0] short_run
    );
        sthc_state_t       r;
        logic              prev;
        logic [HOLD_W-1:0] cnt;
        logic              stop;
        r    = s;
        prev = upward ? s.up_prev : s.down_prev;
        cnt  = upward ? s.up_hold_count : s.down_hold_count;
        stop = 1'b0;
        if (level)
        begin
            if (!prev)
            begin
                cnt  = '0;
                prev = 1'b1;
                if (!r.motor_busy)
                begin
                    r.up_relay   = upward;
                    r.down_relay = !upward;
                    r.motor_busy = 1'b1;
                end
            end
            else if (cnt != HOLD_MAX)
            begin
                cnt = cnt + 1'b1;
            end
        end
        else if (prev)
        begin
            // press length is count + 1
            if (r.run_armed)
            begin
                stop = 1'b1;
            end
            else if (({1'b0, cnt} + 11'd1) < {1'b0, tap_limit})
            begin
                r.run_armed     = 1'b1;
                r.run_remaining = short_run;
            end
            else
            begin
                stop = 1'b1;
            end
            prev = 1'b0;
        end
        else if (r.run_armed && elapsed)
        begin
            stop = 1'b1;
        end
        if (upward)
        begin
            r.up_prev       = prev;
            r.up_hold_count = cnt;
        end
        else
        begin
            r.down_prev       = prev;
            r.down_hold_count = cnt;
        end
        // stop leaves both counts saturated so a held button releases as long
        if (stop)
        begin
            r.up_relay        = 1'b0;
            r.down_relay      = 1'b0;
            r.up_hold_count   = HOLD_MAX;
            r.down_hold_count = HOLD_MAX;
            r.run_remaining   = '0;
            r.run_armed       = 1'b0;
            r.motor_busy      = 1'b0;
        end
        return r;
    endfunction

    sthc_state_t timed;
    sthc_state_t after_up;
    logic        elapsed;

    always_comb
    begin
        timed   = state;
        elapsed = 1'b0;
        if (state.run_armed)
        begin
            if (state.run_remaining == '0)
            begin
                elapsed = 1'b1;
            end
            else
            begin
                timed.run_remaining = state.run_remaining - 1'b1;
            end
        end
        after_up   = handle_button(timed, buttons.button_up_pressed, 1'b1, elapsed,
                                   cfg.tap_limit_ms, cfg.short_run_ms);
        state_next = handle_button(after_up, buttons.button_down_pressed, 1'b0, elapsed,
                                   cfg.tap_limit_ms, cfg.short_run_ms);
        result.relay_up_on      = state_next.up_relay;
        result.relay_down_on    = state_next.down_relay;
        result.timed_run_active = state_next.run_armed;
    end

endmodule

`default_nettype wire

@@ rtl/core/shutter_tap_hold_controller_unit.sv @@
// top level of the roller shutter tap/hold controller
// depends on sthc_pkg, sthc_cfg_regs and sthc_step
//
//   channel   signals                        transaction
//   in        in_valid, in_ready, in_data    one millisecond tick of button levels
//   out       out_valid, out_ready, out_data one set of relay states per tick
//   cfg       cfg_we, cfg_index, cfg_data    register write, no wait
//
// a tick accepted at one edge sits in the input register; the step logic writes
// the result register and the controller state when the tick advances, which a
// stalled out channel holds off; out_valid rises with the result register
// one tick per clock sustained unless out stalls; then, with both registers full,
// in_ready is low and input resumes on the same edge that out_ready returns
// reset clears the controller state and loads the register defaults
`default_nettype none

module shutter_tap_hold_controller_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire sthc_pkg::sthc_in_t               in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output sthc_pkg::sthc_out_t                   out_data,
    input  wire logic                             cfg_we,
    input  wire logic [sthc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sthc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sthc_pkg::*;

    sthc_cfg_t   cfg;
    sthc_state_t state_reg;
    sthc_state_t state_next;
    sthc_out_t   result;
    sthc_in_t    in_data_reg;
    logic        in_valid_reg;
    sthc_out_t   out_data_reg;
    logic        out_valid_reg;
    logic        advance;

    sthc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sthc_step u_step (
        .state      (state_reg),
        .buttons    (in_data_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .result     (result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
